/* rtl/cnv_pkg.sv */
// shared types and constants for the conv5x5 relu maxpool layer
// no dependencies
package cnv_pkg;
  localparam int IMAGE_SIZE = 32;
  localparam int KERNEL_SIZE = 5;
  localparam int DATA_WIDTH = 16;
  localparam int NCHAN = 6;
  localparam int FRAC_BITS = 12;
  localparam int OUT_WIDTH = 20;
  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;

  // classified request from front to back
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] idx;
    logic [31:0] val;
    logic [5:0] row;
    logic [5:0] col;
  } cnv_req_t;
endpackage

/* rtl/conv5x5_relu_maxpool_layer.sv */
// channel   | dir | payload
// s_axis    | in  | tdata {value, load_index}, tuser opcode
// m_axis    | out | tdata {chan5..chan0, pool_col, pool_row}, tlast frame_last
// loads and pixels that complete no conv point are taken while the back end stays idle
// a pixel that completes a conv point holds the back end through accept,
// 25 tap steps shared across six mac lanes, one final add, one pool step
// a pooled result is registered in the pool step of its last conv point
// synchronous active high reset clears counters, queue, row slot, sequencer and output valid
// a held result stalls only the pool step; a two-entry queue decouples input
// top level, depends on cnv_pkg, cnv_front, cnv_back
module conv5x5_relu_maxpool_layer #(
  parameter int IMAGE_SIZE = cnv_pkg::IMAGE_SIZE,
  parameter int KERNEL_SIZE = cnv_pkg::KERNEL_SIZE
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // load_index[7:0], value[23:8]
  input  logic [1:0] s_axis_tuser,   // opcode
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [127:0] m_axis_tdata, // pool_row, pool_col, chan0..chan5
  output logic m_axis_tlast
);
  logic q_valid, q_ready;
  cnv_pkg::cnv_req_t q_req;
  logic [3:0] orow, ocol;
  logic [119:0] ovals;

  cnv_front #(.IMAGE_SIZE(IMAGE_SIZE), .DATA_WIDTH(cnv_pkg::DATA_WIDTH)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(s_axis_tuser), .in_idx(s_axis_tdata[7:0]),
    .in_val(s_axis_tdata[8 +: cnv_pkg::DATA_WIDTH]),
    .q_valid, .q_ready, .q_req);

  cnv_back #(.IMAGE_SIZE(IMAGE_SIZE), .KERNEL_SIZE(KERNEL_SIZE),
             .DATA_WIDTH(cnv_pkg::DATA_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_req,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_row(orow), .out_col(ocol), .out_vals(ovals), .out_last(m_axis_tlast));

  assign m_axis_tdata = {ovals, ocol, orow};
endmodule

/* rtl/cnv_front.sv */
// front end: accepts input requests, tracks pixel position, pushes a queue
// depends on cnv_pkg
module cnv_front #(
  parameter int IMAGE_SIZE = cnv_pkg::IMAGE_SIZE,
  parameter int DATA_WIDTH = cnv_pkg::DATA_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_idx,
  input  logic [DATA_WIDTH-1:0] in_val,
  output logic q_valid,
  input  logic q_ready,
  output cnv_pkg::cnv_req_t q_req
);
  localparam int QD = 2;
  cnv_pkg::cnv_req_t q_mem [QD];
  logic [0:0] wp, rp;
  logic [1:0] cnt;
  logic [5:0] row, col;
  logic push, pop;

  assign in_ready = (cnt != 2'(QD));
  assign push = in_valid && in_ready && (in_op != 2'd3);
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt != 2'd0);
  assign q_req = q_mem[rp];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp].op <= in_op;
      q_mem[wp].idx <= in_idx;
      q_mem[wp].val <= 32'(signed'(in_val));
      q_mem[wp].row <= row;
      q_mem[wp].col <= col;
    end
  end

  // pointers and pixel counters
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; row <= '0; col <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + 2'(push) - 2'(pop);
      if (push && in_op == cnv_pkg::OP_PIXEL) begin
        if (col == 6'(IMAGE_SIZE - 1)) begin
          col <= '0;
          row <= (row == 6'(IMAGE_SIZE - 1)) ? 6'd0 : row + 6'd1;
        end else begin
          col <= col + 6'd1;
        end
      end
    end
  end
endmodule

/* rtl/cnv_back.sv */
// back end: stores, line buffer, shared-tap mac over six channels, pooling
// depends on cnv_pkg
module cnv_back #(
  parameter int IMAGE_SIZE = cnv_pkg::IMAGE_SIZE,
  parameter int KERNEL_SIZE = cnv_pkg::KERNEL_SIZE,
  parameter int DATA_WIDTH = cnv_pkg::DATA_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  cnv_pkg::cnv_req_t q_req,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0] out_row,
  output logic [3:0] out_col,
  output logic [6*20-1:0] out_vals,
  output logic out_last
);
  localparam int KK = KERNEL_SIZE * KERNEL_SIZE;
  localparam int NW = 6 * KK;
  localparam int CONV = IMAGE_SIZE - KERNEL_SIZE + 1;
  localparam int POOL = CONV / 2;
  localparam int LB = KERNEL_SIZE * IMAGE_SIZE;
  localparam int FB = cnv_pkg::FRAC_BITS;
  localparam int AW = 2 * DATA_WIDTH + 8;
  localparam int TW = $clog2(KK);
  localparam int LW = $clog2(LB);
  localparam int PW = (POOL > 1) ? $clog2(POOL) : 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_MAC = 3'd1, S_FIN = 3'd2, S_POOL = 3'd3;

  logic [DATA_WIDTH-1:0] kmem [6][KK];
  logic [DATA_WIDTH-1:0] bias [6];
  logic [DATA_WIDTH-1:0] lbuf [LB];
  logic [6*20-1:0] ppart [POOL];
  logic [19:0] hold [6];

  logic [2:0] state;
  cnv_pkg::cnv_req_t cur;
  logic [2:0] ti, tj;
  logic [TW-1:0] tap;
  logic signed [AW-1:0] acc [6];
  logic signed [DATA_WIDTH-1:0] pix;
  logic signed [DATA_WIDTH-1:0] wt [6];
  logic tap_ok;
  logic [5:0] oh, ow;
  logic [2:0] slot;
  logic [2:0] lslot, cur_slot;
  logic [LW-1:0] raddr, waddr;
  logic [2:0] wch;
  logic [TW-1:0] woff;
  logic [PW-1:0] pc;
  logic [19:0] v [6];
  logic [6*20-1:0] pword, mout;
  logic pool_go, emit;

  assign q_ready = (state == S_IDLE);
  assign oh = cur.row - 6'(KERNEL_SIZE - 1);
  assign ow = cur.col - 6'(KERNEL_SIZE - 1);
  assign pc = PW'(ow >> 1);
  assign pool_go = (state == S_POOL) && (!out_valid || out_ready);
  assign emit = oh[0] && ow[0] && oh < 6'(2 * POOL) && ow < 6'(2 * POOL);
  assign raddr = LW'(int'(slot) * IMAGE_SIZE + int'(ow) + int'(tj));
  assign waddr = LW'(int'(lslot) * IMAGE_SIZE + int'(q_req.col));

  // slot of tap row (oh + ti) mod k from the slot of the current row
  always_comb begin
    logic [3:0] s;
    s = 4'(cur_slot) + 4'(ti) + 4'd1;
    if (s >= 4'(KERNEL_SIZE)) s = s - 4'(KERNEL_SIZE);
    slot = 3'(s);
  end

  // split a weight index into channel and tap by compare and subtract
  always_comb begin
    wch = '0;
    woff = '0;
    for (int c = 0; c < 6; c++)
      if (int'(q_req.idx) >= c * KK) begin
        wch = 3'(c);
        woff = TW'(int'(q_req.idx) - c * KK);
      end
  end

  // loads and pixel write
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      if (q_req.op == cnv_pkg::OP_WEIGHT && int'(q_req.idx) < NW)
        kmem[wch][woff] <= q_req.val[DATA_WIDTH-1:0];
      if (q_req.op == cnv_pkg::OP_BIAS && q_req.idx < 8'd6)
        bias[q_req.idx[2:0]] <= q_req.val[DATA_WIDTH-1:0];
      if (q_req.op == cnv_pkg::OP_PIXEL)
        lbuf[waddr] <= q_req.val[DATA_WIDTH-1:0];
    end
  end

  // line buffer slot of the incoming pixel row, wraps at k and at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      lslot <= '0;
    end else if (q_valid && q_ready && q_req.op == cnv_pkg::OP_PIXEL &&
                 q_req.col == 6'(IMAGE_SIZE - 1)) begin
      if (q_req.row == 6'(IMAGE_SIZE - 1) || lslot == 3'(KERNEL_SIZE - 1)) lslot <= '0;
      else lslot <= lslot + 3'd1;
    end
  end

  // registered reads of the tap pixel and six weights
  always_ff @(posedge clk) begin
    pix <= lbuf[raddr];
    for (int c = 0; c < 6; c++) wt[c] <= kmem[c][tap];
  end

  // relu, truncate and saturate each conv point, then pool against held values
  always_comb begin
    logic [AW-1:0] sh;
    logic [19:0] a, b;
    for (int c = 0; c < 6; c++) begin
      sh = AW'(acc[c] >>> FB);
      if (acc[c] <= 0) v[c] = '0;
      else if (sh > AW'(20'hFFFFF)) v[c] = 20'hFFFFF;
      else v[c] = sh[19:0];
      a = (hold[c] > v[c]) ? hold[c] : v[c];
      pword[c*20 +: 20] = a;
      b = ppart[pc][c*20 +: 20];
      mout[c*20 +: 20] = (b > a) ? b : a;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; tap_ok <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready && q_req.op == cnv_pkg::OP_PIXEL &&
              q_req.row >= 6'(KERNEL_SIZE - 1) && q_req.col >= 6'(KERNEL_SIZE - 1)) begin
            cur <= q_req; cur_slot <= lslot;
            ti <= '0; tj <= '0; tap <= '0; tap_ok <= 1'b0; state <= S_MAC;
            for (int c = 0; c < 6; c++)
              acc[c] <= AW'(signed'(bias[c])) <<< FB;
          end
        end
        S_MAC: begin
          tap_ok <= 1'b1;
          if (tap_ok)
            for (int c = 0; c < 6; c++) acc[c] <= acc[c] + AW'(pix * wt[c]);
          if (tj == 3'(KERNEL_SIZE - 1)) begin
            tj <= '0;
            if (ti == 3'(KERNEL_SIZE - 1)) begin
              state <= S_FIN;
            end else begin
              ti <= ti + 3'd1;
              tap <= tap + 1'b1;
            end
          end else begin
            tj <= tj + 3'd1;
            tap <= tap + 1'b1;
          end
        end
        S_FIN: begin
          for (int c = 0; c < 6; c++) acc[c] <= acc[c] + AW'(pix * wt[c]);
          state <= S_POOL;
        end
        S_POOL: begin
          if (pool_go) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // column pair hold, partial pool row and output register
  always_ff @(posedge clk) begin
    if (pool_go) begin
      if (!ow[0]) begin
        for (int c = 0; c < 6; c++) hold[c] <= v[c];
      end else if (!oh[0] && ow < 6'(2 * POOL)) begin
        ppart[pc] <= pword;
      end
      if (emit) begin
        out_vals <= mout;
        out_row <= 4'(oh >> 1);
        out_col <= 4'(ow >> 1);
        out_last <= (oh >> 1) == 6'(POOL - 1) && (ow >> 1) == 6'(POOL - 1);
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (pool_go) out_valid <= emit;
    else if (out_ready) out_valid <= 1'b0;
  end
endmodule
